### sv/u2i_pkg.sv
package u2i_pkg;

    // Pipeline layout
    localparam int NUM_STAGES = 13;
    localparam int DATE_FIRST = 3;
    localparam int DATE_LAST  = 9;
    localparam int DATE_STAGES = DATE_LAST - DATE_FIRST + 1;
    localparam int HMS_FIRST  = 6;

    localparam int DAYS_W = 22;
    localparam int SOD_W  = 17;
    localparam int YEAR_W = 14;

    // Accepted span: 0000-01-01T00:00:00Z up to 9999-12-31T23:59:59Z
    localparam logic signed [63:0] MIN_SECONDS = -64'sd62167219200;
    localparam logic signed [63:0] MAX_SECONDS = 64'sd253402300799;
    // Seconds from 0000-01-01 to the epoch, a whole number of days
    localparam logic [63:0] SECS_OFFSET = 64'd62167219200;

    localparam int SECS_PER_DAY = 86400;
    localparam int DAY_LOW_BITS = 7;
    localparam int DAY_DIV      = SECS_PER_DAY >> DAY_LOW_BITS;
    localparam int DAYS_PER_ERA = 146097;
    // Days from 0000-01-01 to 0000-03-01 are 60; add one era to stay positive
    localparam int Z_BIAS       = DAYS_PER_ERA - 60;
    localparam int YEARS_PER_ERA = 400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // Floor reciprocal, quotient may come out one low
    localparam int DAY_SHIFT = 41;
    localparam logic [31:0] DAY_RECIP = 32'((64'd1 << DAY_SHIFT) / 64'(DAY_DIV));

    // Ceiling reciprocals, exact over the operand width
    localparam int ERA_SHIFT = 40;
    localparam logic [22:0] ERA_RECIP =
        23'(((64'd1 << ERA_SHIFT) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));
    localparam int S1460 = 29;
    localparam logic [18:0] R1460 = 19'(((64'd1 << S1460) + 64'd1459) / 64'd1460);
    localparam int S36524 = 34;
    localparam logic [18:0] R36524 = 19'(((64'd1 << S36524) + 64'd36523) / 64'd36524);
    localparam int S365 = 27;
    localparam logic [18:0] R365 = 19'(((64'd1 << S365) + 64'd364) / 64'd365);
    localparam int S100 = 16;
    localparam logic [9:0] R100 = 10'(((64'd1 << S100) + 64'd99) / 64'd100);
    localparam int S153 = 19;
    localparam logic [11:0] R153 = 12'(((64'd1 << S153) + 64'd152) / 64'd153);
    localparam int HOUR_SHIFT = 29;
    localparam logic [17:0] HOUR_RECIP =
        18'(((64'd1 << HOUR_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
    localparam int MIN_SHIFT = 18;
    localparam logic [12:0] MIN_RECIP =
        13'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
    localparam int YHI_SHIFT = 21;
    localparam logic [14:0] YHI_RECIP = 15'(((64'd1 << YHI_SHIFT) + 64'd99) / 64'd100);
    localparam int TEN_SHIFT = 11;
    localparam logic [7:0] TEN_RECIP = 8'(((64'd1 << TEN_SHIFT) + 64'd9) / 64'd10);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_DASH  = 8'h2D;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_T     = 8'h54;
    localparam logic [7:0] ASCII_Z     = 8'h5A;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    // Day of the March-based year on which each shifted month starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] base;
        unique case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

    // Two ASCII digits of a value below 100
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'(TEN_RECIP);
        tens = prod[TEN_SHIFT +: 4];
        ones = v - 7'(tens) * 7'd10;
        return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones)};
    endfunction

endpackage

### sv/u2i_seconds_if.sv
interface u2i_seconds_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] unix_secs;

    modport source (output valid, output unix_secs, input ready);
    modport sink   (input valid, input unix_secs, output ready);
endinterface

### sv/u2i_result_if.sv
interface u2i_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [63:0] text_head;
    logic [63:0] text_middle;
    logic [31:0] text_tail;

    modport source (
        output valid, output status, output year, output month, output day,
        output hour, output minute, output second,
        output text_head, output text_middle, output text_tail,
        input ready
    );
    modport sink (
        input valid, input status, input year, input month, input day,
        input hour, input minute, input second,
        input text_head, input text_middle, input text_tail,
        output ready
    );
endinterface

### sv/u2i_date.sv
module u2i_date
    import u2i_pkg::*;
(
    input  logic                   clk,
    input  logic [DATE_STAGES-1:0] load,
    input  logic [DAYS_W-1:0]      days,
    output logic [YEAR_W-1:0]      year,
    output logic [3:0]             month,
    output logic [4:0]             day
);

    // Stage 3: bias into a positive era, take the era
    logic [DAYS_W-1:0] z_reg, z_next;
    logic [4:0]        era3_reg, era3_next;
    logic [44:0]       era_prod;
    // Stage 4: day of era
    logic [17:0]       doe4_reg, doe4_next;
    logic [4:0]        era4_reg;
    logic [DAYS_W-1:0] era_days;
    // Stage 5: leap-corrected day count
    logic [17:0]       t5_reg, t5_next;
    logic [17:0]       doe5_reg;
    logic [4:0]        era5_reg;
    logic [36:0]       p1460, p36524;
    // Stage 6: year of era
    logic [8:0]        yoe6_reg, yoe6_next;
    logic [17:0]       doe6_reg;
    logic [4:0]        era6_reg;
    logic [36:0]       p365;
    // Stage 7: day of the March-based year
    logic [8:0]        doy7_reg, doy7_next;
    logic [8:0]        yoe7_reg;
    logic [4:0]        era7_reg;
    logic [17:0]       c365;
    logic [18:0]       p100;
    // Stage 8: shifted month
    logic [3:0]        mp8_reg, mp8_next;
    logic [8:0]        doy8_reg;
    logic [8:0]        yoe8_reg;
    logic [4:0]        era8_reg;
    logic [10:0]       num153;
    logic [22:0]       p153;
    // Stage 9: calendar fields
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        day_reg, day_next;
    logic [14:0]       year_wide;

    always_comb
    begin
        z_next    = days + DAYS_W'(Z_BIAS);
        era_prod  = 45'(z_next) * 45'(ERA_RECIP);
        era3_next = era_prod[ERA_SHIFT +: 5];

        era_days  = DAYS_W'(era3_reg) * DAYS_W'(DAYS_PER_ERA);
        doe4_next = 18'(z_reg - era_days);

        p1460   = 37'(doe4_reg) * 37'(R1460);
        p36524  = 37'(doe4_reg) * 37'(R36524);
        t5_next = doe4_reg - 18'(p1460[S1460 +: 7]) + 18'(p36524[S36524 +: 3])
                  - 18'(doe4_reg == 18'(DAYS_PER_ERA - 1));

        p365      = 37'(t5_reg) * 37'(R365);
        yoe6_next = p365[S365 +: 9];

        c365      = 18'(yoe6_reg) * 18'd365;
        p100      = 19'(yoe6_reg) * 19'(R100);
        doy7_next = 9'(doe6_reg - (c365 + 18'(yoe6_reg >> 2) - 18'(p100[S100 +: 3])));

        num153   = 11'(doy7_reg) * 11'd5 + 11'd2;
        p153     = 23'(num153) * 23'(R153);
        mp8_next = p153[S153 +: 4];

        day_next   = 5'(doy8_reg - month_start(mp8_reg) + 9'd1);
        month_next = (mp8_reg < 4'd10) ? mp8_reg + 4'd3 : mp8_reg - 4'd9;
        year_wide  = 15'(era8_reg) * 15'(YEARS_PER_ERA) + 15'(yoe8_reg)
                     + 15'(mp8_reg >= 4'd10) - 15'(YEARS_PER_ERA);
        year_next  = year_wide[YEAR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            z_reg    <= z_next;
            era3_reg <= era3_next;
        end
        if (load[1])
        begin
            doe4_reg <= doe4_next;
            era4_reg <= era3_reg;
        end
        if (load[2])
        begin
            t5_reg   <= t5_next;
            doe5_reg <= doe4_reg;
            era5_reg <= era4_reg;
        end
        if (load[3])
        begin
            yoe6_reg <= yoe6_next;
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
        end
        if (load[4])
        begin
            doy7_reg <= doy7_next;
            yoe7_reg <= yoe6_reg;
            era7_reg <= era6_reg;
        end
        if (load[5])
        begin
            mp8_reg  <= mp8_next;
            doy8_reg <= doy7_reg;
            yoe8_reg <= yoe7_reg;
            era8_reg <= era7_reg;
        end
        if (load[6])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

### sv/unix_seconds_to_iso8601.sv
// Converts a signed 64-bit Unix second count into UTC calendar fields and the
// 20-character ISO 8601 text YYYY-MM-DDTHH:MM:SSZ, packed as ASCII with the
// first character in the top byte of text_head. Negative counts round toward
// minus infinity, so times before 1970 come out right. Counts outside
// 0000-01-01T00:00:00Z .. 9999-12-31T23:59:59Z give status 1 and every other
// result field zero. The block is a 13-stage pipeline: one transfer can be
// accepted every cycle while the output is not stalled. Each stage holds at
// most one item and a stage takes a new one whenever it is empty or the
// stage after it moves on, so a stalled output stops only the stages behind
// it that are full; bubbles collapse and input keeps flowing until the
// pipeline is full. The depth is set by the chain of constant divisions
// (day, era, year, month, digits), each done as a reciprocal multiply with a
// register after it.
module unix_seconds_to_iso8601
    import u2i_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    u2i_seconds_if.sink     seconds,
    u2i_result_if.source    result
);

    // Handshake chain: stage i may load when empty or when stage i+1 loads
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   stage_ready;
    logic [NUM_STAGES-1:0] load;

    always_comb
    begin
        stage_ready[NUM_STAGES] = result.ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        load[0] = stage_ready[0] && seconds.valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            load[i] = stage_ready[i] && valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= seconds.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign seconds.ready = stage_ready[0];
    assign result.valid  = valid_reg[NUM_STAGES-1];

    // Status rides along with the item through every stage
    logic status_reg [NUM_STAGES-1];

    // Stage 0: range check, rebase to 0000-01-01 so all later math is unsigned
    logic        status0_next;
    logic [63:0] rebased;
    logic [31:0] x0_reg;
    logic [6:0]  lo7_0_reg;

    // Stage 1: estimate of days = x / 675
    logic [63:0] day_prod;
    logic [22:0] qe1_reg, qe1_next;
    logic [31:0] x1_reg;
    logic [6:0]  lo7_1_reg;

    // Stage 2: correct the estimate, rebuild the second of the day
    logic [31:0]       rem_full;
    logic [10:0]       rem_est;
    logic [DAYS_W-1:0] days2_reg, days2_next;
    logic [SOD_W-1:0]  sod2_reg, sod2_next;

    // Stages 3..6: time of day
    logic [34:0]      hour_prod;
    logic [4:0]       hour3_reg, hour3_next;
    logic [SOD_W-1:0] sod3_reg;
    logic [11:0]      rem4_reg, rem4_next;
    logic [4:0]       hour4_reg;
    logic [24:0]      min_prod;
    logic [5:0]       minute5_reg, minute5_next;
    logic [11:0]      rem5_reg;
    logic [4:0]       hour5_reg;
    hms_t             hms6_next;
    hms_t             hms_reg [HMS_FIRST:NUM_STAGES-2];

    // Stage 9 output of the date core, then year digits
    logic [YEAR_W-1:0] date_year;
    logic [3:0]        date_month;
    logic [4:0]        date_day;
    logic [28:0]       yhi_prod;
    logic [6:0]        yhi10_reg, yhi10_next;
    logic [YEAR_W-1:0] year10_reg;
    logic [3:0]        month10_reg;
    logic [4:0]        day10_reg;
    logic [6:0]        yhi11_reg;
    logic [6:0]        ylo11_reg, ylo11_next;
    logic [YEAR_W-1:0] year11_reg;
    logic [3:0]        month11_reg;
    logic [4:0]        day11_reg;

    // Stage 12: output register
    logic        status_out_reg;
    logic [13:0] year_out_reg,  year_out_next;
    logic [3:0]  month_out_reg, month_out_next;
    logic [4:0]  day_out_reg,   day_out_next;
    hms_t        hms_out_reg,   hms_out_next;
    logic [63:0] head_reg,      head_next;
    logic [63:0] middle_reg,    middle_next;
    logic [31:0] tail_reg,      tail_next;

    always_comb
    begin
        status0_next = (seconds.unix_secs < MIN_SECONDS) ||
                       (seconds.unix_secs > MAX_SECONDS);
        rebased      = $unsigned(seconds.unix_secs) + SECS_OFFSET;

        day_prod = 64'(x0_reg) * 64'(DAY_RECIP);
        qe1_next = day_prod[DAY_SHIFT +: 23];

        // Estimate is exact or one low: one compare and subtract fixes it
        rem_full = x1_reg - 32'(qe1_reg) * 32'(DAY_DIV);
        rem_est  = rem_full[10:0];
        if (rem_est >= 11'(DAY_DIV))
        begin
            days2_next = DAYS_W'(qe1_reg + 23'd1);
            sod2_next  = {10'(rem_est - 11'(DAY_DIV)), lo7_1_reg};
        end
        else
        begin
            days2_next = DAYS_W'(qe1_reg);
            sod2_next  = {rem_est[9:0], lo7_1_reg};
        end

        hour_prod  = 35'(sod2_reg) * 35'(HOUR_RECIP);
        hour3_next = hour_prod[HOUR_SHIFT +: 5];

        rem4_next = 12'(sod3_reg - 17'(hour3_reg) * 17'(SECS_PER_HOUR));

        min_prod     = 25'(rem4_reg) * 25'(MIN_RECIP);
        minute5_next = min_prod[MIN_SHIFT +: 6];

        hms6_next.hour   = hour5_reg;
        hms6_next.minute = minute5_reg;
        hms6_next.second = 6'(rem5_reg - 12'(minute5_reg) * 12'(SECS_PER_MIN));

        yhi_prod   = 29'(date_year) * 29'(YHI_RECIP);
        yhi10_next = yhi_prod[YHI_SHIFT +: 7];

        ylo11_next = 7'(year10_reg - YEAR_W'(yhi10_reg) * YEAR_W'(100));

        // Drop everything but the status for an out-of-range time
        if (status_reg[NUM_STAGES-2])
        begin
            year_out_next  = '0;
            month_out_next = '0;
            day_out_next   = '0;
            hms_out_next   = '0;
            head_next      = '0;
            middle_next    = '0;
            tail_next      = '0;
        end
        else
        begin
            year_out_next  = year11_reg;
            month_out_next = month11_reg;
            day_out_next   = day11_reg;
            hms_out_next   = hms_reg[NUM_STAGES-2];
            head_next      = {two_digits(yhi11_reg), two_digits(ylo11_reg), ASCII_DASH,
                              two_digits(7'(month11_reg)), ASCII_DASH};
            middle_next    = {two_digits(7'(day11_reg)), ASCII_T,
                              two_digits(7'(hms_reg[NUM_STAGES-2].hour)), ASCII_COLON,
                              two_digits(7'(hms_reg[NUM_STAGES-2].minute))};
            tail_next      = {ASCII_COLON, two_digits(7'(hms_reg[NUM_STAGES-2].second)),
                              ASCII_Z};
        end
    end

    u2i_date u_date (
        .clk   (clk),
        .load  (load[DATE_LAST:DATE_FIRST]),
        .days  (days2_reg),
        .year  (date_year),
        .month (date_month),
        .day   (date_day)
    );

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            status_reg[0] <= status0_next;
            x0_reg        <= rebased[38:7];
            lo7_0_reg     <= rebased[6:0];
        end
        for (int i = 1; i < NUM_STAGES - 1; i++)
        begin
            if (load[i])
            begin
                status_reg[i] <= status_reg[i-1];
            end
        end
        if (load[1])
        begin
            qe1_reg   <= qe1_next;
            x1_reg    <= x0_reg;
            lo7_1_reg <= lo7_0_reg;
        end
        if (load[2])
        begin
            days2_reg <= days2_next;
            sod2_reg  <= sod2_next;
        end
        if (load[3])
        begin
            hour3_reg <= hour3_next;
            sod3_reg  <= sod2_reg;
        end
        if (load[4])
        begin
            rem4_reg  <= rem4_next;
            hour4_reg <= hour3_reg;
        end
        if (load[5])
        begin
            minute5_reg <= minute5_next;
            rem5_reg    <= rem4_reg;
            hour5_reg   <= hour4_reg;
        end
        if (load[HMS_FIRST])
        begin
            hms_reg[HMS_FIRST] <= hms6_next;
        end
        for (int i = HMS_FIRST + 1; i < NUM_STAGES - 1; i++)
        begin
            if (load[i])
            begin
                hms_reg[i] <= hms_reg[i-1];
            end
        end
        if (load[10])
        begin
            yhi10_reg   <= yhi10_next;
            year10_reg  <= date_year;
            month10_reg <= date_month;
            day10_reg   <= date_day;
        end
        if (load[11])
        begin
            yhi11_reg   <= yhi10_reg;
            ylo11_reg   <= ylo11_next;
            year11_reg  <= year10_reg;
            month11_reg <= month10_reg;
            day11_reg   <= day10_reg;
        end
        if (load[NUM_STAGES-1])
        begin
            status_out_reg <= status_reg[NUM_STAGES-2];
            year_out_reg   <= year_out_next;
            month_out_reg  <= month_out_next;
            day_out_reg    <= day_out_next;
            hms_out_reg    <= hms_out_next;
            head_reg       <= head_next;
            middle_reg     <= middle_next;
            tail_reg       <= tail_next;
        end
    end

    assign result.status      = status_out_reg;
    assign result.year        = year_out_reg;
    assign result.month       = month_out_reg;
    assign result.day         = day_out_reg;
    assign result.hour        = hms_out_reg.hour;
    assign result.minute      = hms_out_reg.minute;
    assign result.second      = hms_out_reg.second;
    assign result.text_head   = head_reg;
    assign result.text_middle = middle_reg;
    assign result.text_tail   = tail_reg;

    // An out-of-range result has zero year, month, day, text head and text tail
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |->
            result.year == '0 && result.month == '0 && result.day == '0 &&
            result.text_head == '0 && result.text_tail == '0)
    else $error("out-of-range result has nonzero fields");

    // A valid date and time stay inside calendar limits
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.status |->
            result.month >= 4'd1 && result.month <= 4'd12 &&
            result.day >= 5'd1 && result.day <= 5'd31 &&
            result.hour <= 5'd23 && result.minute <= 6'd59 && result.second <= 6'd59)
    else $error("calendar field out of bounds");

    // The last dash, the T, the Z and the second colon of the text sit where the format puts them
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.status |->
            result.text_head[7:0] == ASCII_DASH && result.text_middle[47:40] == ASCII_T &&
            result.text_tail[7:0] == ASCII_Z && result.text_tail[31:24] == ASCII_COLON)
    else $error("text separators misplaced");

    // An empty first stage always takes an input
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> seconds.ready)
    else $error("empty pipeline refused input");

endmodule
